### rtl/core/bcpt_pkg.sv
// shared types, constants and codes of the battery coulomb and peak tracker
package bcpt_pkg;

    localparam int CUR_W   = 17;
    localparam int VOLT_W  = 17;
    localparam int AVG_W   = 17;
    localparam int POW_W   = 33;
    localparam int CHG_W   = 32;
    localparam int RES_W   = 34;
    localparam int PROD_W  = 34;
    localparam int SCALE_W = 16;
    localparam int QUANT_W = 32;
    localparam int DEAD_W  = 16;

    localparam int CMD_W     = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 32;

    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 136;

    localparam int AVG_LEN_DEF = 8;

    localparam logic [SCALE_W-1:0] SCALE_RST = 16'd125;
    localparam logic [QUANT_W-1:0] QUANT_RST = 32'd3600000;
    localparam logic [DEAD_W-1:0]  DEAD_RST  = 16'd2;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK       = 2'd0,
        CMD_CLR_PEAK   = 2'd1,
        CMD_CLR_CHARGE = 2'd2
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CHARGE_SCALE   = 2'd0,
        REG_CHARGE_QUANTUM = 2'd1,
        REG_DEADBAND       = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [CMD_W-1:0]         cmd;
        logic signed [CUR_W-1:0]  cur;
        logic [VOLT_W-1:0]        volt;
        logic signed [PROD_W-1:0] chg;
        logic                     over;
    } t_tick;

endpackage

### rtl/core/battery_coulomb_and_peak_tracker_top.sv
// battery coulomb counter with window averaging and peak power tracking
// a transaction accepted is held in the input register, then in the result register until taken
// throughput: one transaction per cycle; the input register and the result register
// run as a two-entry pipeline that stalls only when the result side holds off
// reset: synchronous active low, clears sums, averages, peak record, residue, count
// and restores configuration to charge_scale 125, quantum 3600000, deadband 2
module battery_coulomb_and_peak_tracker_top #(
    parameter int AVG_LEN = bcpt_pkg::AVG_LEN_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // current_ma [16:0], voltage_mv [33:17], zero [39:34]
    input  logic [bcpt_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // cmd [1:0]
    input  logic [bcpt_pkg::CMD_W-1:0]          s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // avg_current [16:0], avg_voltage [33:17], max_power [66:34],
    // peak_voltage [83:67], peak_current [100:84], charge_count [132:101], zero [135:133]
    output logic [bcpt_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [bcpt_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [bcpt_pkg::CFG_DAT_W-1:0]      i_cfg_data
);

    localparam int LG    = $clog2(AVG_LEN);
    localparam int SUM_W = bcpt_pkg::AVG_W + LG;
    localparam int CNT_W = $clog2(AVG_LEN + 1);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(AVG_LEN);
    localparam logic [SUM_W-1:0] CUR_OFS  = SUM_W'(AVG_LEN) << (bcpt_pkg::CUR_W - 1);
    localparam logic signed [bcpt_pkg::RES_W:0] RES_MAX = {2'b00, {(bcpt_pkg::RES_W-1){1'b1}}};
    localparam logic signed [bcpt_pkg::RES_W:0] RES_MIN = {2'b11, {(bcpt_pkg::RES_W-1){1'b0}}};
    localparam logic signed [bcpt_pkg::CHG_W-1:0] TOT_MAX = {1'b0, {(bcpt_pkg::CHG_W-1){1'b1}}};
    localparam logic signed [bcpt_pkg::CHG_W-1:0] TOT_MIN = {1'b1, {(bcpt_pkg::CHG_W-1){1'b0}}};

    // configuration
    logic [bcpt_pkg::SCALE_W-1:0] r_cfg_scale;
    logic [bcpt_pkg::QUANT_W-1:0] r_cfg_quant;
    logic [bcpt_pkg::DEAD_W-1:0]  r_cfg_dead;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_scale <= bcpt_pkg::SCALE_RST;
            r_cfg_quant <= bcpt_pkg::QUANT_RST;
            r_cfg_dead  <= bcpt_pkg::DEAD_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                bcpt_pkg::REG_CHARGE_SCALE:   r_cfg_scale <= i_cfg_data[bcpt_pkg::SCALE_W-1:0];
                bcpt_pkg::REG_CHARGE_QUANTUM: r_cfg_quant <= i_cfg_data[bcpt_pkg::QUANT_W-1:0];
                bcpt_pkg::REG_DEADBAND:       r_cfg_dead  <= i_cfg_data[bcpt_pkg::DEAD_W-1:0];
                default: ;
            endcase
        end
    end

    // input stage
    logic                            r_s1_valid;
    bcpt_pkg::t_tick                 r_s1;
    bcpt_pkg::t_tick                 n_s1;
    logic                            r_out_valid;
    logic                            w_adv;
    logic                            w_in_fire;
    logic                            w_fire2;
    logic signed [bcpt_pkg::CUR_W:0] w_cur_x;
    logic [bcpt_pkg::CUR_W:0]        w_cur_mag;

    assign w_adv         = !r_out_valid || m_axis_tready;
    assign w_fire2       = r_s1_valid && w_adv;
    assign s_axis_tready = !r_s1_valid || w_adv;
    assign w_in_fire     = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_s1.cmd  = s_axis_tuser;
        n_s1.cur  = $signed(s_axis_tdata[bcpt_pkg::CUR_W-1:0]);
        n_s1.volt = s_axis_tdata[bcpt_pkg::CUR_W +: bcpt_pkg::VOLT_W];
        n_s1.chg  = bcpt_pkg::PROD_W'($signed({1'b0, r_cfg_scale}))
                  * bcpt_pkg::PROD_W'(n_s1.cur);
        w_cur_x   = (bcpt_pkg::CUR_W+1)'(n_s1.cur);
        w_cur_mag = w_cur_x[bcpt_pkg::CUR_W] ? -w_cur_x : w_cur_x;
        n_s1.over = w_cur_mag > (bcpt_pkg::CUR_W+1)'(r_cfg_dead);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_in_fire) begin
            r_s1_valid <= 1'b1;
        end else if (w_fire2) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_s1 <= n_s1;
        end
    end

    // tracker state
    logic signed [SUM_W-1:0]             r_cur_sum,   n_cur_sum;
    logic [SUM_W-1:0]                    r_volt_sum,  n_volt_sum;
    logic [CNT_W-1:0]                    r_win_cnt,   n_win_cnt;
    logic signed [bcpt_pkg::AVG_W-1:0]   r_avg_cur,   n_avg_cur;
    logic [bcpt_pkg::AVG_W-1:0]          r_avg_volt,  n_avg_volt;
    logic signed [bcpt_pkg::AVG_W-1:0]   r_pend_cur,  n_pend_cur;
    logic [bcpt_pkg::AVG_W-1:0]          r_pend_volt, n_pend_volt;
    logic [bcpt_pkg::POW_W-1:0]          r_peak_pow,  n_peak_pow;
    logic [bcpt_pkg::AVG_W-1:0]          r_peak_volt, n_peak_volt;
    logic signed [bcpt_pkg::AVG_W-1:0]   r_peak_cur,  n_peak_cur;
    logic signed [bcpt_pkg::RES_W-1:0]   r_residue,   n_residue;
    logic signed [bcpt_pkg::CHG_W-1:0]   r_total,     n_total;

    logic signed [SUM_W-1:0]             w_acc_cur;
    logic [SUM_W-1:0]                    w_acc_volt;
    logic [SUM_W-1:0]                    w_cur_num;
    logic [bcpt_pkg::AVG_W-1:0]          w_cur_quot;
    logic [bcpt_pkg::AVG_W-1:0]          w_volt_quot;
    logic signed [bcpt_pkg::AVG_W-1:0]   w_op_cur;
    logic [bcpt_pkg::AVG_W-1:0]          w_op_volt;
    logic signed [bcpt_pkg::AVG_W*2:0]   w_pow_raw;
    logic signed [bcpt_pkg::AVG_W*2:0]   w_pow_abs;
    logic [bcpt_pkg::POW_W-1:0]          w_pow;
    logic signed [bcpt_pkg::RES_W:0]     w_res_sum;
    logic signed [bcpt_pkg::RES_W:0]     w_res_sat;
    logic signed [bcpt_pkg::RES_W:0]     w_quant;
    logic                                w_publish;

    assign w_acc_cur  = r_cur_sum + SUM_W'(r_s1.cur);
    assign w_acc_volt = r_volt_sum + SUM_W'(r_s1.volt);
    assign w_cur_num  = $unsigned(w_acc_cur) + CUR_OFS;

    bcpt_div_const #(.AVG_LEN(AVG_LEN)) u_div_cur (
        .i_num  (w_cur_num),
        .o_quot (w_cur_quot)
    );

    bcpt_div_const #(.AVG_LEN(AVG_LEN)) u_div_volt (
        .i_num  (w_acc_volt),
        .o_quot (w_volt_quot)
    );

    always_comb begin
        n_cur_sum   = r_cur_sum;
        n_volt_sum  = r_volt_sum;
        n_win_cnt   = r_win_cnt;
        n_avg_cur   = r_avg_cur;
        n_avg_volt  = r_avg_volt;
        n_peak_pow  = r_peak_pow;
        n_peak_volt = r_peak_volt;
        n_peak_cur  = r_peak_cur;
        n_residue   = r_residue;
        n_total     = r_total;
        w_publish   = (r_win_cnt == CNT_LAST);

        // window accumulation, the pending average is ready before its publish tick
        if (!w_publish) begin
            n_cur_sum  = w_acc_cur;
            n_volt_sum = w_acc_volt;
        end
        n_pend_cur  = $signed({~w_cur_quot[bcpt_pkg::AVG_W-1], w_cur_quot[bcpt_pkg::AVG_W-2:0]});
        n_pend_volt = w_volt_quot;

        w_op_cur  = w_publish ? r_pend_cur : r_avg_cur;
        w_op_volt = w_publish ? r_pend_volt : r_avg_volt;
        w_pow_raw = (bcpt_pkg::AVG_W*2+1)'(w_op_cur)
                  * (bcpt_pkg::AVG_W*2+1)'($signed({1'b0, w_op_volt}));
        w_pow_abs = w_pow_raw[bcpt_pkg::AVG_W*2] ? -w_pow_raw : w_pow_raw;
        w_pow     = w_pow_abs[bcpt_pkg::POW_W-1:0];

        w_quant   = $signed({{(bcpt_pkg::RES_W+1-bcpt_pkg::QUANT_W){1'b0}}, r_cfg_quant});
        w_res_sum = (bcpt_pkg::RES_W+1)'(r_residue) + (bcpt_pkg::RES_W+1)'(r_s1.chg);
        if (w_res_sum > RES_MAX) begin
            w_res_sat = RES_MAX;
        end else if (w_res_sum < RES_MIN) begin
            w_res_sat = RES_MIN;
        end else begin
            w_res_sat = w_res_sum;
        end

        case (r_s1.cmd)
            bcpt_pkg::CMD_TICK: begin
                if (w_publish) begin
                    n_cur_sum  = '0;
                    n_volt_sum = '0;
                    n_win_cnt  = '0;
                    n_avg_cur  = r_pend_cur;
                    n_avg_volt = r_pend_volt;
                end else begin
                    n_win_cnt  = r_win_cnt + CNT_W'(1);
                end
                if (w_pow > r_peak_pow) begin
                    n_peak_pow  = w_pow;
                    n_peak_volt = w_op_volt;
                    n_peak_cur  = w_op_cur;
                end
                if (r_s1.over) begin
                    n_residue = w_res_sat[bcpt_pkg::RES_W-1:0];
                    if (w_res_sat > w_quant) begin
                        if (r_total != TOT_MAX) begin
                            n_residue = bcpt_pkg::RES_W'(w_res_sat - w_quant);
                            n_total   = r_total + bcpt_pkg::CHG_W'(1);
                        end
                    end else if (w_res_sat < -w_quant) begin
                        if (r_total != TOT_MIN) begin
                            n_residue = bcpt_pkg::RES_W'(w_res_sat + w_quant);
                            n_total   = r_total - bcpt_pkg::CHG_W'(1);
                        end
                    end
                end
            end
            bcpt_pkg::CMD_CLR_PEAK: begin
                n_cur_sum   = r_cur_sum;
                n_volt_sum  = r_volt_sum;
                n_peak_pow  = '0;
                n_peak_volt = '0;
                n_peak_cur  = '0;
            end
            bcpt_pkg::CMD_CLR_CHARGE: begin
                n_cur_sum  = r_cur_sum;
                n_volt_sum = r_volt_sum;
                n_residue  = '0;
                n_total    = '0;
            end
            default: begin
                n_cur_sum  = r_cur_sum;
                n_volt_sum = r_volt_sum;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_sum   <= '0;
            r_volt_sum  <= '0;
            r_win_cnt   <= '0;
            r_avg_cur   <= '0;
            r_avg_volt  <= '0;
            r_pend_cur  <= '0;
            r_pend_volt <= '0;
            r_peak_pow  <= '0;
            r_peak_volt <= '0;
            r_peak_cur  <= '0;
            r_residue   <= '0;
            r_total     <= '0;
        end else if (w_fire2) begin
            r_cur_sum   <= n_cur_sum;
            r_volt_sum  <= n_volt_sum;
            r_win_cnt   <= n_win_cnt;
            r_avg_cur   <= n_avg_cur;
            r_avg_volt  <= n_avg_volt;
            if (r_s1.cmd == bcpt_pkg::CMD_TICK && !w_publish) begin
                r_pend_cur  <= n_pend_cur;
                r_pend_volt <= n_pend_volt;
            end
            r_peak_pow  <= n_peak_pow;
            r_peak_volt <= n_peak_volt;
            r_peak_cur  <= n_peak_cur;
            r_residue   <= n_residue;
            r_total     <= n_total;
        end
    end

    // result register
    logic [bcpt_pkg::OUT_DATA_W-1:0] r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire2) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire2) begin
            r_out_data <= {3'b000, n_total, n_peak_cur, n_peak_volt, n_peak_pow,
                           n_avg_volt, n_avg_cur};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // checks
    a_win_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_win_cnt <= CNT_LAST)
        else $error("window count past window length");

    a_clr_charge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire2 && r_s1.cmd == bcpt_pkg::CMD_CLR_CHARGE |=> r_total == '0 && r_residue == '0)
        else $error("charge clear did not take effect");

    a_peak_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire2 && r_s1.cmd != bcpt_pkg::CMD_CLR_PEAK |=> r_peak_pow >= $past(r_peak_pow))
        else $error("peak power dropped without a clear");

    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !w_adv |=> r_s1_valid && $stable(r_s1))
        else $error("input stage lost a stalled transaction");

    a_state_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_fire2 |=> $stable(r_total) && $stable(r_win_cnt) && $stable(r_peak_pow))
        else $error("tracker state moved without a transaction");

endmodule

### rtl/core/bcpt_div_const.sv
// floor division of an unsigned window sum by the window length via reciprocal multiply
module bcpt_div_const #(
    parameter int AVG_LEN = bcpt_pkg::AVG_LEN_DEF
) (
    input  logic [bcpt_pkg::AVG_W+$clog2(AVG_LEN)-1:0] i_num,
    output logic [bcpt_pkg::AVG_W-1:0]                  o_quot
);

    localparam int LG = $clog2(AVG_LEN);
    localparam int UW = bcpt_pkg::AVG_W + LG;
    localparam int K  = UW + LG;
    localparam int MW = UW + 2;
    localparam longint unsigned MUL = ((64'd1 << K) + 64'(AVG_LEN) - 64'd1) / 64'(AVG_LEN);

    logic [MW-1:0]    w_mul;
    logic [UW+MW-1:0] w_prod;

    assign w_mul  = MW'(MUL);
    assign w_prod = (UW+MW)'(i_num) * (UW+MW)'(w_mul);
    assign o_quot = w_prod[K +: bcpt_pkg::AVG_W];

endmodule

### tb/sv/battery_coulomb_and_peak_tracker_top_test.sv
// self-checking testbench for the battery coulomb counter and peak power tracker
`timescale 1ns / 1ps

module battery_coulomb_and_peak_tracker_top_test;
    import bcpt_pkg::*;

    localparam int     WIN_LEN     = AVG_LEN_DEF;
    localparam int     CYCLE_LIMIT = 800000;
    localparam longint RES_MAX     = (longint'(1) <<< 33) - 1;
    localparam longint RES_MIN     = -(longint'(1) <<< 33);
    localparam longint CHG_MAX     = 64'sd2147483647;
    localparam longint CHG_MIN     = -64'sd2147483648;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [AVG_W-1:0]  avg_cur;
        logic [AVG_W-1:0]  avg_volt;
        logic [POW_W-1:0]  peak_pow;
        logic [VOLT_W-1:0] peak_volt;
        logic [CUR_W-1:0]  peak_cur;
        logic [CHG_W-1:0]  charge;
    } t_report;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic [CMD_W-1:0]      s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DAT_W-1:0]  i_cfg_data;

    // tracker state mirrored by the testbench
    longint trk_cur_sum, trk_volt_sum, trk_avg_cur, trk_avg_volt;
    longint trk_peak_pow, trk_peak_volt, trk_peak_cur, trk_residue, trk_charge;
    int     trk_win;
    longint trk_scale, trk_quantum, trk_dead;

    t_report report_q[$];
    int      fail_count;
    int      items_sent;
    int      results_checked;
    int      reg_writes;
    int      settings_used;
    int      cycles;
    bit      idle_on;
    int      sink_hold;
    int      sink_gap;

    battery_coulomb_and_peak_tracker_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycles, report_q.size());
            $display("** battery_coulomb_and_peak_tracker_top: FAILED **");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        if (!idle_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // result side ready with random stalls and a requested long hold
    always @(negedge i_clk) begin
        if (sink_hold > 0) begin
            m_axis_tready <= 1'b0;
            sink_hold <= sink_hold - 1;
        end else if (sink_gap > 0) begin
            m_axis_tready <= 1'b0;
            sink_gap <= sink_gap - 1;
        end else begin
            m_axis_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0) sink_gap <= pick_gap();
        end
    end

    function automatic void report_fail(string what, logic [63:0] want, logic [63:0] got);
        fail_count++;
        if (fail_count <= 10)
            $display("mismatch at result %0d, %s: expected %0h, got %0h",
                     results_checked, what, want, got);
    endfunction

    function automatic void check_field(string what, logic [63:0] want, logic [63:0] got);
        if (want !== got) report_fail(what, want, got);
    endfunction

    always @(posedge i_clk) begin : check_results
        t_report want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (report_q.size() == 0) begin
                report_fail("result with nothing pending", '0, m_axis_tdata[63:0]);
            end else begin
                want = report_q.pop_front();
                results_checked++;
                check_field("avg_current",  64'(want.avg_cur),   64'(m_axis_tdata[16:0]));
                check_field("avg_voltage",  64'(want.avg_volt),  64'(m_axis_tdata[33:17]));
                check_field("max_power",    64'(want.peak_pow),  64'(m_axis_tdata[66:34]));
                check_field("peak_voltage", 64'(want.peak_volt), 64'(m_axis_tdata[83:67]));
                check_field("peak_current", 64'(want.peak_cur),  64'(m_axis_tdata[100:84]));
                check_field("charge_count", 64'(want.charge),    64'(m_axis_tdata[132:101]));
            end
        end
    end

    task automatic clear_tracker();
        trk_cur_sum = 0;
        trk_volt_sum = 0;
        trk_win = 0;
        trk_avg_cur = 0;
        trk_avg_volt = 0;
        trk_peak_pow = 0;
        trk_peak_volt = 0;
        trk_peak_cur = 0;
        trk_residue = 0;
        trk_charge = 0;
        trk_scale = longint'(SCALE_RST);
        trk_quantum = longint'(QUANT_RST);
        trk_dead = longint'(DEAD_RST);
    endtask

    function automatic longint floor_avg(longint s);
        longint q;
        q = s / WIN_LEN;
        if ((s % WIN_LEN) != 0 && s < 0) q = q - 1;
        return q;
    endfunction

    task automatic sample_tick(longint c, longint v);
        longint p;
        longint mag;
        if (trk_win >= WIN_LEN) begin
            trk_avg_cur = floor_avg(trk_cur_sum);
            trk_avg_volt = floor_avg(trk_volt_sum);
            trk_cur_sum = 0;
            trk_volt_sum = 0;
            trk_win = 0;
        end else begin
            trk_cur_sum += c;
            trk_volt_sum += v;
            trk_win++;
        end
        p = trk_avg_cur * trk_avg_volt;
        if (p < 0) p = -p;
        if (p > trk_peak_pow) begin
            trk_peak_pow = p;
            trk_peak_volt = trk_avg_volt;
            trk_peak_cur = trk_avg_cur;
        end
        mag = (c < 0) ? -c : c;
        if (mag > trk_dead) begin
            trk_residue += trk_scale * c;
            if (trk_residue > RES_MAX) trk_residue = RES_MAX;
            if (trk_residue < RES_MIN) trk_residue = RES_MIN;
            if (trk_residue > trk_quantum) begin
                if (trk_charge < CHG_MAX) begin
                    trk_residue -= trk_quantum;
                    trk_charge += 1;
                end
            end else if (trk_residue < -trk_quantum) begin
                if (trk_charge > CHG_MIN) begin
                    trk_residue += trk_quantum;
                    trk_charge -= 1;
                end
            end
        end
    endtask

    task automatic predict_report(logic [CMD_W-1:0] cmd, logic signed [CUR_W-1:0] cur,
                                  logic [VOLT_W-1:0] volt);
        t_report r;
        longint  c;
        longint  v;
        c = longint'(cur);
        v = longint'(volt);
        case (cmd)
            CMD_TICK: sample_tick(c, v);
            CMD_CLR_PEAK: begin
                trk_peak_pow = 0;
                trk_peak_volt = 0;
                trk_peak_cur = 0;
            end
            CMD_CLR_CHARGE: begin
                trk_charge = 0;
                trk_residue = 0;
            end
            default: ;
        endcase
        r.avg_cur = trk_avg_cur[16:0];
        r.avg_volt = trk_avg_volt[16:0];
        r.peak_pow = trk_peak_pow[32:0];
        r.peak_volt = trk_peak_volt[16:0];
        r.peak_cur = trk_peak_cur[16:0];
        r.charge = trk_charge[31:0];
        report_q.push_back(r);
    endtask

    // returns at the rising edge where the transaction was taken
    task automatic send_item(logic [CMD_W-1:0] cmd, logic signed [CUR_W-1:0] cur,
                             logic [VOLT_W-1:0] volt);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {6'd0, volt, cur};
        s_axis_tuser <= cmd;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_report(cmd, cur, volt);
        items_sent++;
    endtask

    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (report_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [CFG_DAT_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_CHARGE_SCALE:   trk_scale = longint'(val[15:0]);
            REG_CHARGE_QUANTUM: trk_quantum = longint'(val);
            REG_DEADBAND:       trk_dead = longint'(val[15:0]);
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic configure(logic [15:0] scale, logic [31:0] quantum, logic [15:0] dead);
        drain();
        write_reg(REG_CHARGE_SCALE, {16'd0, scale});
        write_reg(REG_CHARGE_QUANTUM, quantum);
        write_reg(REG_DEADBAND, {16'd0, dead});
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    function automatic logic signed [CUR_W-1:0] rand_current();
        longint v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = longint'($urandom_range(0, 131071)) - 65536;
            4, 5: begin
                v = trk_dead + longint'($urandom_range(0, 2)) - 1;
                if ($urandom_range(0, 1) == 1) v = -v;
            end
            6: v = ($urandom_range(0, 1) == 1) ? 65535 : -65536;
            default: v = longint'($urandom_range(0, 4000)) - 2000;
        endcase
        if (v > 65535) v = 65535;
        if (v < -65536) v = -65536;
        return v[16:0];
    endfunction

    function automatic logic [VOLT_W-1:0] rand_voltage();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return VOLT_W'($urandom_range(0, 131071));
    endfunction

    function automatic logic [CMD_W-1:0] rand_cmd();
        int r;
        r = $urandom_range(0, 99);
        if (r < 90) return CMD_TICK;
        if (r < 94) return CMD_CLR_PEAK;
        if (r < 98) return CMD_CLR_CHARGE;
        return CMD_UNUSED;
    endfunction

    task automatic send_random(int n);
        repeat (n) send_item(rand_cmd(), rand_current(), rand_voltage());
    endtask

    // full scale window at reset settings, then every command
    task automatic test_reset_window();
        repeat (WIN_LEN) send_item(CMD_TICK, -17'sd65536, 17'd131071);
        send_item(CMD_TICK, 17'sd65535, 17'd0);
        send_item(CMD_CLR_PEAK, 17'sd65535, 17'd131071);
        send_item(CMD_TICK, 17'sd3, 17'd1);
        send_item(CMD_CLR_CHARGE, -17'sd65536, 17'd0);
        send_item(CMD_UNUSED, 17'sd12345, 17'd54321);
    endtask

    task automatic test_quantum_edges();
        // residue equal to one quantum stays, one more moves
        configure(16'd1, 32'd100, 16'd0);
        send_item(CMD_TICK, 17'sd100, 17'd500);
        send_item(CMD_TICK, 17'sd1, 17'd500);
        send_item(CMD_TICK, -17'sd201, 17'd500);
        send_item(CMD_TICK, 17'sd0, 17'd500);
        // deadband at its top
        configure(16'hFFFF, 32'd1, 16'hFFFF);
        send_item(CMD_TICK, 17'sd65535, 17'd100);
        send_item(CMD_TICK, -17'sd65536, 17'd100);
        // zero quantum and residue saturation
        configure(16'hFFFF, 32'd0, 16'd0);
        repeat (3) send_item(CMD_TICK, 17'sd65535, 17'd131071);
        send_item(CMD_TICK, -17'sd1, 17'd131071);
        // largest quantum, negative side
        configure(16'hFFFF, 32'hFFFF_FFFF, 16'd0);
        repeat (3) send_item(CMD_TICK, -17'sd65536, 17'd0);
    endtask

    task automatic test_random_ticks(logic [15:0] scale, logic [31:0] quantum,
                                     logic [15:0] dead, bit with_idle, int n);
        configure(scale, quantum, dead);
        idle_on = with_idle;
        send_random(n);
        idle_on = 1'b1;
    endtask

    task automatic test_backpressure();
        drain();
        @(posedge i_clk);
        sink_hold = 400;
        send_random(50);
        // sender waits for every pending result, then resumes
        drain();
        send_random(30);
    endtask

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = CMD_TICK;
        m_axis_tready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_CHARGE_SCALE;
        i_cfg_data = '0;
        fail_count = 0;
        items_sent = 0;
        results_checked = 0;
        reg_writes = 0;
        settings_used = 1;
        cycles = 0;
        idle_on = 1'b1;
        sink_hold = 0;
        sink_gap = 0;
        clear_tracker();

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_window();
        test_quantum_edges();
        test_random_ticks(SCALE_RST, QUANT_RST, DEAD_RST, 1'b1, 300);
        test_random_ticks(16'd0, 32'd1, 16'd0, 1'b1, 200);
        test_random_ticks(16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b0, 200);
        test_random_ticks(16'hFFFF, 32'd1, 16'd0, 1'b1, 200);
        test_random_ticks(16'd300, 32'd0, 16'd5, 1'b1, 150);
        test_backpressure();
        test_random_ticks(16'($urandom_range(1, 65535)), $urandom(),
                          16'($urandom_range(0, 300)), 1'b1, 450);

        drain();
        repeat (8) @(posedge i_clk);
        if (report_q.size() != 0) report_fail("results never arrived", 64'(report_q.size()), '0);

        $display("covered %0d transactions under %0d settings with %0d register writes",
                 items_sent, settings_used, reg_writes);
        $display("checked %0d results, %0d failures", results_checked, fail_count);
        if (fail_count == 0) begin
            $display("** battery_coulomb_and_peak_tracker_top: PASSED **");
        end else begin
            $display("** battery_coulomb_and_peak_tracker_top: FAILED **");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/core/bcpt_pkg.sv
rtl/core/bcpt_div_const.sv
rtl/core/battery_coulomb_and_peak_tracker_top.sv
tb/sv/battery_coulomb_and_peak_tracker_top_test.sv
